// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define KVCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvcd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define KVCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvcd assertion failed");

`endif

// ===== src/kvcd_pkg.sv =====
// ----------------------------------------------------------------------------
// kvcd_pkg
// shared types and codes of the key-value command deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvcd_pkg;

  // opcode bytes on the wire
  localparam logic [7:0] OPC_BYTE_PUT   = 8'd11;
  localparam logic [7:0] OPC_BYTE_DEL   = 8'd12;
  localparam logic [7:0] OPC_BYTE_GET   = 8'd13;
  localparam logic [7:0] OPC_BYTE_TAKE  = 8'd14;
  localparam logic [7:0] OPC_BYTE_STATS = 8'd21;

  // number of big-endian bytes in a length field
  localparam int unsigned LEN_BYTES = 4;

  // command codes
  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_DEL   = 3'd1;
  localparam logic [2:0] CMD_GET   = 3'd2;
  localparam logic [2:0] CMD_TAKE  = 3'd3;
  localparam logic [2:0] CMD_STATS = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_STATS    = 3'd0;
  localparam logic [2:0] KIND_KEY_LEN  = 3'd1;
  localparam logic [2:0] KIND_KEY_BYTE = 3'd2;
  localparam logic [2:0] KIND_VAL_LEN  = 3'd3;
  localparam logic [2:0] KIND_VAL_BYTE = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_OPC  = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  // configuration register indexes
  localparam logic REG_MAX_KEY_LEN = 1'b0;
  localparam logic REG_MAX_VAL_LEN = 1'b1;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65535;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  opcode;
    logic [7:0]  data_byte;
    logic [31:0] length;
    logic        last;
    logic [1:0]  error;
  } kvcd_result_t;

  typedef struct packed {
    logic [31:0] max_key_length;
    logic [31:0] max_value_length;
  } kvcd_limits_t;

endpackage

// ===== src/kvcd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kvcd_cfg_regs
// apb register file holding the key and value length limits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvcd_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output kvcd_pkg::kvcd_limits_t limits_o
);
  import kvcd_pkg::*;

  logic [31:0] max_key_q, max_key_d;
  logic [31:0] max_val_q, max_val_d;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  // byte lanes inside a word are ignored
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    max_key_d = max_key_q;
    max_val_d = max_val_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_KEY_LEN: max_key_d = pwdata;
        REG_MAX_VAL_LEN: max_val_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_key_q <= MAX_LEN_RESET;
      max_val_q <= MAX_LEN_RESET;
    end else begin
      max_key_q <= max_key_d;
      max_val_q <= max_val_d;
    end
  end

  assign prdata = (reg_sel == REG_MAX_VAL_LEN) ? max_val_q : max_key_q;

  assign limits_o.max_key_length   = max_key_q;
  assign limits_o.max_value_length = max_val_q;

endmodule

// ===== src/kvcd_parser.sv =====
// ----------------------------------------------------------------------------
// kvcd_parser
// command state machine: consumes one byte per step and forms the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvcd_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  kvcd_pkg::kvcd_limits_t limits_i,
  output logic                   res_valid_o,
  output kvcd_pkg::kvcd_result_t res_o
);
  import kvcd_pkg::*;

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_KEYLEN = 3'd1,
    PH_KEY    = 3'd2,
    PH_VALLEN = 3'd3,
    PH_VAL    = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  opc_q, opc_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;

  logic        key_side;
  logic        is_put;
  logic [31:0] len;
  logic [31:0] limit;
  logic        done;
  logic [7:0]  opc_off;

  assign key_side = (phase_q == PH_KEYLEN) || (phase_q == PH_KEY);
  assign is_put   = (opc_q == CMD_PUT);
  assign len      = {acc_q, byte_i};
  assign limit    = key_side ? limits_i.max_key_length : limits_i.max_value_length;
  assign done     = (rem_q <= 32'd1);
  assign opc_off  = byte_i - OPC_BYTE_PUT;

  always_comb begin
    phase_d     = phase_q;
    opc_d       = opc_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.opcode = opc_q;

    unique case (phase_q)
      PH_KEYLEN, PH_VALLEN: begin
        if (cnt_q != 2'(LEN_BYTES - 1)) begin
          acc_d = {acc_q[15:0], byte_i};
          cnt_d = cnt_q + 2'd1;
        end else begin
          acc_d        = '0;
          cnt_d        = '0;
          res_valid_o  = 1'b1;
          res_o.kind   = key_side ? KIND_KEY_LEN : KIND_VAL_LEN;
          res_o.length = len;
          if (len > limit) begin
            res_o.last  = 1'b1;
            res_o.error = ERR_TOO_LONG;
            phase_d     = PH_OPCODE;
            rem_d       = '0;
          end else begin
            rem_d = len;
            if (len != '0) begin
              phase_d = key_side ? PH_KEY : PH_VAL;
            end else if (key_side && is_put) begin
              // empty key of a put: value length follows directly
              phase_d = PH_VALLEN;
            end else begin
              phase_d    = PH_OPCODE;
              res_o.last = 1'b1;
            end
          end
        end
      end

      PH_KEY, PH_VAL: begin
        res_valid_o     = 1'b1;
        res_o.kind      = key_side ? KIND_KEY_BYTE : KIND_VAL_BYTE;
        res_o.data_byte = byte_i;
        res_o.last      = done && !(key_side && is_put);
        rem_d           = done ? '0 : rem_q - 32'd1;
        if (done) begin
          phase_d = (key_side && is_put) ? PH_VALLEN : PH_OPCODE;
        end
      end

      // opcode phase, unused phase codes land here too
      default: begin
        phase_d = PH_OPCODE;
        acc_d   = '0;
        cnt_d   = '0;
        rem_d   = '0;
        unique case (byte_i)
          OPC_BYTE_PUT, OPC_BYTE_DEL, OPC_BYTE_GET, OPC_BYTE_TAKE: begin
            opc_d   = opc_off[2:0];
            phase_d = PH_KEYLEN;
          end
          OPC_BYTE_STATS: begin
            opc_d        = CMD_STATS;
            res_valid_o  = 1'b1;
            res_o.kind   = KIND_STATS;
            res_o.opcode = CMD_STATS;
            res_o.last   = 1'b1;
          end
          default: begin
            res_valid_o  = 1'b1;
            res_o.kind   = KIND_STATS;
            res_o.opcode = CMD_PUT;
            res_o.last   = 1'b1;
            res_o.error  = ERR_BAD_OPC;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      opc_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      opc_q   <= opc_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ===== src/kv_command_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// kv_command_deframer_unit
// splits a binary key-value request byte stream into command results
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | in_byte_i
//  out     | output    | out_valid_o/out_stall_i | kind, opcode, data_byte, length,
//          |           |                      | last, error
//  cfg     | input     | apb psel/penable     | max_key_length, max_value_length
//
// one item per cycle while out_stall_i is low; an item goes input register ->
// parser -> result register, which loads only when the item yields a result
// the parser steps only when the result register is empty or being drained
// reset clears the handshake state and returns the parser to the opcode phase
// out_stall_i holds the result register and, once the input register is full,
// raises in_stall_o in the same cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kv_command_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [2:0]  opcode_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] length_o,
  output logic        last_o,
  output logic [1:0]  error_o
);
  import kvcd_pkg::*;

  kvcd_limits_t limits;
  kvcd_result_t res;
  kvcd_result_t res_q;
  logic         res_valid;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  logic         step;
  logic         in_accept;
  logic         out_take;

  kvcd_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .limits_o (limits)
  );

  kvcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .limits_i    (limits),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_take   = out_valid_q && !out_stall_i;
  // result slot is free this cycle when empty or being taken
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign opcode_o    = res_q.opcode;
  assign data_byte_o = res_q.data_byte;
  assign length_o    = res_q.length;
  assign last_o      = res_q.last;
  assign error_o     = res_q.error;

endmodule

// ===== src/kvcd_checker.sv =====
// ----------------------------------------------------------------------------
// kvcd_checker
// port-level checks of the deframer result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kvcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [31:0] length_o,
  input logic        last_o,
  input logic [1:0]  error_o
);
  import kvcd_pkg::*;

  // a stalled result is never dropped
  `KVCD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // an unknown opcode ends the command as a lone stats-kind result
  `KVCD_ASSERT_IMP(a_bad_opc, clk_i, rst_ni, out_valid_o && (error_o == ERR_BAD_OPC),
                   last_o && (kind_o == KIND_STATS))

  // a length error is always reported on a header and closes the command
  `KVCD_ASSERT_IMP(a_too_long, clk_i, rst_ni, out_valid_o && (error_o == ERR_TOO_LONG),
                   last_o && ((kind_o == KIND_KEY_LEN) || (kind_o == KIND_VAL_LEN)))

  // passed-through bytes carry no length and no error
  `KVCD_ASSERT_IMP(a_byte_clean, clk_i, rst_ni,
                   out_valid_o && ((kind_o == KIND_KEY_BYTE) || (kind_o == KIND_VAL_BYTE)),
                   (length_o == '0) && (error_o == ERR_NONE))

endmodule

bind kv_command_deframer_unit kvcd_checker u_kvcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .length_o    (length_o),
  .last_o      (last_o),
  .error_o     (error_o)
);

// ===== bench/kv_command_deframer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// kv_command_deframer_unit_tb
// self-checking bench for the key-value command deframer: byte streams of
// well-formed, truncated and noisy commands go in, a cycle-free model of the
// parser predicts every result, and each result is compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kv_command_deframer_unit_tb;
  import kvcd_pkg::*;

  typedef enum logic [2:0] {PH_OPCODE, PH_KEY_LEN, PH_KEY, PH_VAL_LEN, PH_VAL} deframe_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [2:0]  opcode_o;
  logic [7:0]  data_byte_o;
  logic [31:0] length_o;
  logic        last_o;
  logic [1:0]  error_o;

  kv_command_deframer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .opcode_o    (opcode_o),
    .data_byte_o (data_byte_o),
    .length_o    (length_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  always #6 clk_i = ~clk_i;

  // parser model state
  deframe_phase_e parse_phase = PH_OPCODE;
  logic [2:0]     cur_cmd = CMD_PUT;
  logic [31:0]    len_acc = '0;
  logic [1:0]     len_cnt = '0;
  logic [31:0]    bytes_left = '0;
  logic [31:0]    key_len_limit = MAX_LEN_RESET;
  logic [31:0]    val_len_limit = MAX_LEN_RESET;

  kvcd_result_t results_due[$];
  kvcd_result_t got_result;
  kvcd_result_t want_result;

  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int stall_left = 0;

  // one byte through the parser model; returns 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output kvcd_result_t r);
    logic [31:0] len;
    logic [31:0] limit;
    logic [7:0]  code;
    bit          is_key;
    bit          is_put;
    bit          done;
    r = '0;
    is_put = (cur_cmd == CMD_PUT);
    case (parse_phase)
      PH_KEY_LEN, PH_VAL_LEN: begin
        is_key = (parse_phase == PH_KEY_LEN);
        limit = is_key ? key_len_limit : val_len_limit;
        len_acc = {len_acc[23:0], b};
        if (len_cnt != 2'd3) begin
          len_cnt = len_cnt + 2'd1;
          return 1'b0;
        end
        len = len_acc;
        len_acc = '0;
        len_cnt = '0;
        r.kind = is_key ? KIND_KEY_LEN : KIND_VAL_LEN;
        r.opcode = cur_cmd;
        r.length = len;
        if (len > limit) begin
          r.last = 1'b1;
          r.error = ERR_TOO_LONG;
          parse_phase = PH_OPCODE;
          bytes_left = '0;
        end else begin
          bytes_left = len;
          if (len != 0) begin
            parse_phase = is_key ? PH_KEY : PH_VAL;
          end else if (is_key && is_put) begin
            parse_phase = PH_VAL_LEN;
          end else begin
            parse_phase = PH_OPCODE;
            r.last = 1'b1;
          end
        end
        return 1'b1;
      end
      PH_KEY, PH_VAL: begin
        is_key = (parse_phase == PH_KEY);
        done = (bytes_left <= 1);
        r.kind = is_key ? KIND_KEY_BYTE : KIND_VAL_BYTE;
        r.opcode = cur_cmd;
        r.data_byte = b;
        r.last = done && !(is_key && is_put);
        bytes_left = done ? 32'd0 : bytes_left - 1;
        if (done) parse_phase = (is_key && is_put) ? PH_VAL_LEN : PH_OPCODE;
        return 1'b1;
      end
      default: begin
        parse_phase = PH_OPCODE;
        len_acc = '0;
        len_cnt = '0;
        bytes_left = '0;
        case (b)
          OPC_BYTE_PUT, OPC_BYTE_DEL, OPC_BYTE_GET, OPC_BYTE_TAKE: begin
            code = b - OPC_BYTE_PUT;
            cur_cmd = code[2:0];
            parse_phase = PH_KEY_LEN;
            return 1'b0;
          end
          OPC_BYTE_STATS: begin
            cur_cmd = CMD_STATS;
            r.kind = KIND_STATS;
            r.opcode = CMD_STATS;
            r.last = 1'b1;
            return 1'b1;
          end
          default: begin
            r.kind = KIND_STATS;
            r.opcode = CMD_PUT;
            r.last = 1'b1;
            r.error = ERR_BAD_OPC;
            return 1'b1;
          end
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // mostly small lengths, sometimes over the limit (one over it, or a random word for a small limit)
  function automatic logic [31:0] pick_length(input logic [31:0] limit);
    logic [31:0] top;
    top = (limit < 6) ? limit : 32'd6;
    if ($urandom_range(99) < 12) begin
      if (limit <= 32'd255) return $urandom;
      if (limit != 32'hFFFF_FFFF) return limit + 1;
    end
    if ($urandom_range(4) == 0) return 32'd0;
    return $urandom_range(top, 0);
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_result = '{kind_o, opcode_o, data_byte_o, length_o, last_o, error_o};
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result kind %0d opcode %0d arrived with nothing expected", kind_o, opcode_o);
        mismatches++;
      end else begin
        want_result = results_due.pop_front();
        check_field("kind", want_result.kind, got_result.kind);
        check_field("opcode", want_result.opcode, got_result.opcode);
        check_field("data_byte", want_result.data_byte, got_result.data_byte);
        check_field("length", want_result.length, got_result.length);
        check_field("last", want_result.last, got_result.last);
        check_field("error", want_result.error, got_result.error);
      end
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- driving
  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    kvcd_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (deframe_byte(b, r)) results_due.push_back(r);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
  endtask

  // cut >= 0 stops after that many key/value bytes, leaving the command open if it had more
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] key_len,
                              input logic [31:0] val_len, input int cut);
    logic [7:0] opc;
    opc = (cmd == CMD_STATS) ? OPC_BYTE_STATS : OPC_BYTE_PUT + {5'd0, cmd};
    send_byte(opc);
    if (cmd == CMD_STATS) return;
    send_length(key_len);
    while (parse_phase == PH_KEY && cut != 0) begin
      send_byte(rand_byte());
      cut--;
    end
    if (parse_phase == PH_VAL_LEN) send_length(val_len);
    while (parse_phase == PH_VAL && cut != 0) begin
      send_byte(rand_byte());
      cut--;
    end
  endtask

  // bring the parser back to the opcode phase
  task automatic resync();
    while (parse_phase != PH_OPCODE)
      send_byte((parse_phase == PH_KEY || parse_phase == PH_VAL) ? rand_byte() : 8'h00);
  endtask

  // stop sending and wait until every predicted result is in
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    // let items that give no result clear the pipeline
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_MAX_KEY_LEN) key_len_limit = value;
    else val_len_limit = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_byte(OPC_BYTE_STATS);
    send_byte(8'h00);
    send_byte(8'hFF);
    // delete with an empty key ends on its header
    send_command(CMD_DEL, 32'd0, 32'd0, -1);
    // put with one key byte and an empty value
    send_byte(OPC_BYTE_PUT);
    send_length(32'd1);
    send_byte(8'hFF);
    send_length(32'd0);
    send_byte(OPC_BYTE_GET);
    send_length(32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_backpressure();
    set_limit(REG_MAX_KEY_LEN, 32'd4);
    set_limit(REG_MAX_VAL_LEN, 32'd4);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 60;
    for (int i = 0; i < 4; i++) send_command(CMD_PUT, 32'd4, 32'd3, -1);
    drain_results();
  endtask

  task automatic test_random(input int n_items, input int snd_idle, input int rcv_idle,
                             input logic [31:0] key_lim, input logic [31:0] val_lim,
                             input bit allow_broken);
    int          start;
    int          pick;
    logic [2:0]  cmd;
    set_limit(REG_MAX_KEY_LEN, key_lim);
    set_limit(REG_MAX_VAL_LEN, val_lim);
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      resync();
      pick = $urandom_range(99);
      cmd = 3'($urandom_range(CMD_STATS, CMD_PUT));
      if (pick < 8) begin
        send_byte(rand_byte());
      end else if (pick < 18 && allow_broken) begin
        send_command(cmd, pick_length(key_len_limit), pick_length(val_len_limit),
                     $urandom_range(3));
      end else begin
        send_command(cmd, pick_length(key_len_limit), pick_length(val_len_limit), -1);
      end
    end
    resync();
    drain_results();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(420, 10, 59, 32'd8, 32'd5, 1'b1);
    test_random(420, 59, 10, 32'd0, 32'd0, 1'b1);
    test_random(420, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    repeat (8) @(negedge clk_i);
    $display("run covered %0d input bytes and %0d results", bytes_sent, results_seen);
    $display("limits went from zero to all ones, with truncated commands and noise bytes");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", results_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/kvcd_pkg.sv
src/kvcd_cfg_regs.sv
src/kvcd_parser.sv
src/kv_command_deframer_unit.sv
src/kvcd_checker.sv
bench/kv_command_deframer_unit_tb.sv
